@@ sv/ansi_escape_stripper_defines.svh @@
// assertion macros for the ansi escape stripper
// used by the top level only; no other dependencies
`ifndef ANSI_ESCAPE_STRIPPER_DEFINES_SVH
`define ANSI_ESCAPE_STRIPPER_DEFINES_SVH

`ifndef SYNTHESIS

// checked at each clock edge, off while reset is low
`define AES_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at each clock edge, also while reset is low
`define AES_ASSERT_NR(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define AES_ASSERT(lbl, prop, msg)
`define AES_ASSERT_NR(lbl, prop, msg)

`endif

`endif

@@ sv/aes_pkg.sv @@
// shared types and character constants for the ansi escape stripper
// no dependencies
package aes_pkg;

    localparam logic [7:0] CH_BEL  = 8'd7;
    localparam logic [7:0] CH_ESC  = 8'd27;
    localparam logic [7:0] CH_CSI8 = 8'h9B;
    localparam logic [7:0] CH_ST8  = 8'h9C;
    localparam logic [7:0] CH_LBRK = 8'h5B;
    localparam logic [7:0] CH_RBRK = 8'h5D;
    localparam logic [7:0] CH_BSL  = 8'h5C;

    localparam logic [7:0] TWO_BYTE_LO = 8'd64;
    localparam logic [7:0] TWO_BYTE_HI = 8'd95;
    localparam logic [7:0] CSI_END_LO  = 8'd64;
    localparam logic [7:0] CSI_END_HI  = 8'd126;

    localparam int AES_QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PS_TEXT    = 3'd0,
        PS_ESC     = 3'd1,
        PS_CSI     = 3'd2,
        PS_OSC     = 3'd3,
        PS_OSC_ESC = 3'd4
    } t_parse_state;

    // one emit command: a byte, preceded by ESC when two is set
    typedef struct packed {
        logic       two;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ sv/ansi_escape_stripper.sv @@
// ansi escape stripper top level: parser front, command queue, output back
// depends on aes_pkg, aes_front, aes_queue, aes_back and the defines header
//
// input channel: one terminal byte per request on i_in_byte, valid/ready.
// output channel: cleaned bytes on o_out_byte with o_last_of_run, valid/ready;
// o_last_of_run marks the final byte caused by one input byte.
// escape sequences (csi, osc, two-byte esc codes) and text bel are removed
// and give no output. esc followed by an ordinary byte gives two outputs,
// esc then the byte.
// throughput: one input byte per cycle while the queue is not full; the output
// side gives one byte per cycle while the receiver is ready.
// path: the queue is written when the input is accepted, and the output
// register loads from the queue head when it is empty or its byte is taken;
// o_out_valid and o_out_byte come straight from that register.
// reset (synchronous, active low) returns the parser to plain text and
// empties the queue and the output register.
// when the receiver stalls, the output register holds its request and the
// queue fills; o_in_ready drops only when the queue is full.
`include "ansi_escape_stripper_defines.svh"

module ansi_escape_stripper #(
    parameter int QUEUE_DEPTH = aes_pkg::AES_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run
);
    import aes_pkg::*;

    // parser to queue
    logic      w_push;
    t_cmd      w_cmd;
    // queue to output side
    t_cmd      w_head;
    t_q_status w_q_status;
    logic      w_pop;

    aes_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in_valid),
        .i_byte     (i_in_byte),
        .o_ready    (o_in_ready),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_cmd      (w_cmd)
    );

    aes_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    aes_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (w_q_status),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_byte     (o_out_byte),
        .o_last     (o_last_of_run)
    );

    // a non-final output is always the esc lead-in
    `AES_ASSERT(a_lead_is_esc, (o_out_valid && !o_last_of_run) |-> (o_out_byte == CH_ESC), "non-final output byte is not esc")
    // the partner byte follows the esc lead-in right away
    `AES_ASSERT(a_pair_follows, (o_out_valid && i_out_ready && !o_last_of_run) |=> (o_out_valid && o_last_of_run), "esc lead-in not followed by its byte")
    // queue never takes a push while full
    `AES_ASSERT(a_no_overflow, w_q_status.full |-> !w_push, "push into full queue")
    // reset empties the output register
    `AES_ASSERT_NR(a_reset_clears, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

@@ sv/aes_front.sv @@
// front end: parses the byte stream and queues emit commands
// depends on aes_pkg
module aes_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [7:0]         i_byte,
    output logic               o_ready,
    input  aes_pkg::t_q_status i_q_status,
    output logic               o_push,
    output aes_pkg::t_cmd      o_cmd
);
    import aes_pkg::*;

    t_parse_state r_state;
    t_parse_state n_state;
    logic         w_accept;

    assign o_ready  = !i_q_status.full;
    assign w_accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_TEXT;
        end else if (w_accept) begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = PS_TEXT;
        unique case (r_state)
            PS_TEXT: begin
                if (i_byte == CH_ESC) begin
                    n_state = PS_ESC;
                end else if (i_byte == CH_CSI8) begin
                    n_state = PS_CSI;
                end
            end
            PS_ESC: begin
                if (i_byte == CH_LBRK) begin
                    n_state = PS_CSI;
                end else if (i_byte == CH_RBRK) begin
                    n_state = PS_OSC;
                end
            end
            PS_CSI: begin
                if (!(i_byte >= CSI_END_LO && i_byte <= CSI_END_HI)) begin
                    n_state = PS_CSI;
                end
            end
            PS_OSC: begin
                if (i_byte == CH_ESC) begin
                    n_state = PS_OSC_ESC;
                end else if (i_byte != CH_BEL && i_byte != CH_ST8) begin
                    n_state = PS_OSC;
                end
            end
            PS_OSC_ESC: begin
                n_state = (i_byte == CH_BSL) ? PS_TEXT : PS_OSC;
            end
            default: n_state = PS_TEXT;
        endcase
    end

    // emit command
    always_comb begin
        o_push      = 1'b0;
        o_cmd.two   = 1'b0;
        o_cmd.data  = i_byte;
        unique case (r_state)
            PS_TEXT: begin
                o_push = w_accept && i_byte != CH_ESC && i_byte != CH_CSI8
                         && i_byte != CH_BEL;
            end
            PS_ESC: begin
                o_cmd.two = 1'b1;
                o_push    = w_accept && i_byte != CH_LBRK && i_byte != CH_RBRK
                            && !(i_byte >= TWO_BYTE_LO && i_byte <= TWO_BYTE_HI);
            end
            default: o_push = 1'b0;
        endcase
    end

endmodule

@@ sv/aes_queue.sv @@
// short command queue between the parser and the output side
// depends on aes_pkg
module aes_queue #(
    parameter int DEPTH = aes_pkg::AES_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  aes_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output aes_pkg::t_cmd      o_head,
    output aes_pkg::t_q_status o_status
);
    import aes_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_count;
    logic          w_push;
    logic          w_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_head = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ sv/aes_back.sv @@
// back end: expands queued commands into output requests
// depends on aes_pkg
module aes_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  aes_pkg::t_q_status i_q_status,
    input  aes_pkg::t_cmd      i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_byte,
    output logic               o_last
);
    import aes_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_last;
    logic       r_esc_sent;
    logic       w_load;
    logic       w_first;

    assign w_load  = !r_valid || i_ready;
    // head needs its ESC lead-in first
    assign w_first = i_head.two && !r_esc_sent;
    assign o_pop   = w_load && !i_q_status.empty && !w_first;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_esc_sent <= 1'b0;
        end else if (w_load) begin
            r_valid    <= !i_q_status.empty;
            if (!i_q_status.empty) begin
                r_esc_sent <= w_first;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && !i_q_status.empty) begin
            r_byte <= w_first ? CH_ESC : i_head.data;
            r_last <= !w_first;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
    assign o_last  = r_last;

endmodule
